// ----- hw/rtl/sss_pkg.sv -----
package sss_pkg;

	typedef struct packed {
		logic [3:0]         state_index;
		logic               last_state;
		logic               start_sequence;
		logic signed [31:0] u_value;
		logic signed [31:0] delta_value;
		logic signed [31:0] a_value;
		logic signed [31:0] b_value;
		logic signed [31:0] c_value;
		logic signed [31:0] d_value;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] y_value;
		logic               saturated;
	} out_item_t;

	localparam logic signed [47:0] MAX48 = 48'sh7FFF_FFFF_FFFF;
	localparam logic signed [47:0] MIN48 = -48'sh8000_0000_0000;
	localparam logic signed [47:0] X_MIN = -48'sd268435456;
	localparam logic signed [47:0] X_MAX = 48'sd67108864;
	localparam logic signed [47:0] LOG2E_Q = 48'sd24204406;
	localparam logic signed [47:0] LN2_Q = 48'sd11629080;
	localparam logic signed [47:0] P_INIT = 48'sd23302;

	function automatic logic signed [47:0] coef(input logic [2:0] i);
		logic signed [47:0] r;
		begin
			case (i)
				3'd0: r = 48'sd139810;
				3'd1: r = 48'sd699051;
				3'd2: r = 48'sd2796203;
				3'd3: r = 48'sd8388608;
				default: r = 48'sd16777216;
			endcase
			return r;
		end
	endfunction

	function automatic logic signed [47:0] sat48(input logic signed [48:0] v);
		logic signed [47:0] r;
		begin
			if (v > 49'(MAX48)) r = MAX48;
			else if (v < 49'(MIN48)) r = MIN48;
			else r = v[47:0];
			return r;
		end
	endfunction

endpackage

// ----- hw/rtl/sss_mul.sv -----
// Q.24 multiply of two 48-bit signed values: truncation toward zero and
// 48-bit saturation. Magnitudes are split into 24-bit halves; the four
// partial products are registered, then summed, truncated and saturated into the registered product.
module sss_mul
	import sss_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [47:0] op_a,
	input  logic signed [47:0] op_b,
	output logic               done,
	output logic signed [47:0] prod
);
	logic [47:0] mag_a, mag_b;
	logic [47:0] pll_s1, plh_s1, phl_s1, phh_s1;
	logic        neg_s1, vld_s1;
	logic [95:0] full;
	logic [48:0] mag;
	logic [47:0] lim;

	assign mag_a = op_a[47] ? 48'(-op_a) : op_a;
	assign mag_b = op_b[47] ? 48'(-op_b) : op_b;

	always_ff @(posedge clk) begin
		pll_s1 <= mag_a[23:0] * mag_b[23:0];
		plh_s1 <= mag_a[23:0] * mag_b[47:24];
		phl_s1 <= mag_a[47:24] * mag_b[23:0];
		phh_s1 <= mag_a[47:24] * mag_b[47:24];
		neg_s1 <= op_a[47] ^ op_b[47];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			done <= 1'b0;
		end else begin
			vld_s1 <= start;
			done <= vld_s1;
		end
	end

	always_comb begin
		full = 96'(pll_s1) + (96'(plh_s1) << 24) + (96'(phl_s1) << 24)
			+ (96'(phh_s1) << 48);
		lim = neg_s1 ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;
		if (full[95:72] != 24'd0) mag = 49'(lim);
		else mag = {1'b0, full[71:24]};
		if (mag > 49'(lim)) mag = 49'(lim);
	end

	always_ff @(posedge clk) begin
		if (vld_s1) prod <= neg_s1 ? 48'(-mag[47:0]) : mag[47:0];
	end
endmodule

// ----- hw/rtl/selective_state_space_scan.sv -----
// Channel | Direction | Handshake            | Payload
// in      | input     | in_valid / in_ready  | in_item_t
// out     | output    | out_valid / out_ready| out_item_t
//
// An item inside the store is carried through to the end before the next item can transfer.
// A sequencer runs 14 products in turn through one Q.24 multiplier, waiting for each to return
// before the next issues; an item beyond the store goes straight to the done state.
// The hidden store is a synchronous memory read at the transfer and held until needed.
// Reset clears the control state and the accumulator; the store is not cleared.
// A waiting result blocks only the next item that carries a last mark.
module selective_state_space_scan
	import sss_pkg::*;
#(
	parameter int N_HIDDEN = 16
)(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_item,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_item
);
	localparam int AW = (N_HIDDEN > 1) ? $clog2(N_HIDDEN) : 1;

	typedef enum logic [3:0] {
		S_IDLE, S_X, S_T, S_R, S_POLY, S_SHIFT, S_EH, S_DB, S_DBU,
		S_DU, S_CH, S_DONE
	} st_t;

	st_t               st_q;
	in_item_t          it_q;
	logic              inr_q;
	logic signed [47:0] mem [N_HIDDEN];
	logic signed [47:0] hprev_q, e_q, h_q, acc_q, p_q;
	logic signed [6:0]  k_q;
	logic [2:0]         cnt_q;
	logic               wait_q;
	logic               m_start;
	logic signed [47:0] m_a, m_b, m_p;
	logic               m_done;
	logic signed [47:0] x_c, tb;
	logic signed [31:0] acc_hi;
	logic               in_range;

	sss_mul u_mul (
		.clk, .arst_n, .start(m_start), .op_a(m_a), .op_b(m_b),
		.done(m_done), .prod(m_p)
	);

	assign in_range = (N_HIDDEN >= 16) || (32'(in_item.state_index) < N_HIDDEN);
	assign in_ready = (st_q == S_IDLE) && !(out_valid && in_item.last_state);

	always_ff @(posedge clk) begin
		if (in_valid && in_ready && in_range)
			hprev_q <= mem[AW'(in_item.state_index)];
		if (st_q == S_CH && m_done && inr_q)
			mem[AW'(it_q.state_index)] <= h_q;
	end

	always_comb begin
		x_c = m_p;
		if (m_p < X_MIN) x_c = X_MIN;
		if (m_p > X_MAX) x_c = X_MAX;
		tb = m_p + 48'sd536870912;
		acc_hi = 32'(acc_q);
	end

	// Most steps wait for the product issued before them and issue the next; done marks its return.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			acc_q <= '0;
			out_valid <= 1'b0;
			out_item <= '0;
			wait_q <= 1'b0;
			m_start <= 1'b0;
			it_q <= '0;
			inr_q <= 1'b0;
			m_a <= '0;
			m_b <= '0;
			k_q <= '0;
			e_q <= '0;
			h_q <= '0;
			p_q <= '0;
			cnt_q <= '0;
		end else begin
			m_start <= 1'b0;
			if (out_valid && out_ready) out_valid <= 1'b0;
			case (st_q)
				S_IDLE: begin
					if (in_valid && in_ready) begin
						it_q <= in_item;
						inr_q <= in_range;
						if (in_range) begin
							m_a <= 48'(in_item.delta_value);
							m_b <= 48'(in_item.a_value);
							m_start <= 1'b1;
							st_q <= S_X;
						end else st_q <= S_DONE;
					end
				end
				S_X: if (m_done) begin
					m_a <= x_c; m_b <= LOG2E_Q; m_start <= 1'b1; st_q <= S_T;
				end
				S_T: if (m_done) begin
					k_q <= 7'(tb[31:24]) - 7'sd32;
					m_a <= {24'd0, tb[23:0]}; m_b <= LN2_Q; m_start <= 1'b1;
					st_q <= S_R;
				end
				S_R: if (m_done) begin
					e_q <= m_p;
					m_a <= P_INIT; m_b <= m_p; m_start <= 1'b1;
					cnt_q <= '0; st_q <= S_POLY;
				end
				S_POLY: if (m_done) begin
					p_q <= m_p + coef(cnt_q);
					if (cnt_q == 3'd5) st_q <= S_SHIFT;
					else begin
						m_a <= m_p + coef(cnt_q); m_b <= e_q; m_start <= 1'b1;
						cnt_q <= cnt_q + 3'd1;
					end
				end
				S_SHIFT: begin
					if (k_q >= 0) e_q <= p_q << k_q[2:0];
					else e_q <= p_q >>> 7'(-k_q);
					m_a <= (k_q >= 0) ? (p_q << k_q[2:0]) : (p_q >>> 7'(-k_q));
					m_b <= it_q.start_sequence ? '0 : hprev_q;
					m_start <= 1'b1; st_q <= S_EH;
				end
				S_EH: if (m_done) begin
					h_q <= m_p;
					m_a <= 48'(it_q.delta_value); m_b <= 48'(it_q.b_value);
					m_start <= 1'b1; st_q <= S_DB;
				end
				S_DB: if (m_done) begin
					m_a <= m_p; m_b <= 48'(it_q.u_value); m_start <= 1'b1;
					st_q <= S_DBU;
				end
				S_DBU: if (m_done) begin
					h_q <= sat48(49'(h_q) + 49'(m_p));
					m_a <= 48'(it_q.d_value); m_b <= 48'(it_q.u_value);
					m_start <= 1'b1; st_q <= S_DU;
				end
				S_DU: if (m_done) begin
					if (it_q.state_index == '0) acc_q <= m_p;
					m_a <= 48'(it_q.c_value); m_b <= h_q; m_start <= 1'b1;
					st_q <= S_CH;
				end
				S_CH: if (m_done) begin
					acc_q <= sat48(49'(acc_q) + 49'(m_p));
					st_q <= S_DONE;
				end
				S_DONE: begin
					if (it_q.last_state) begin
						out_valid <= 1'b1;
						if (acc_q > 48'sh7FFF_FFFF) begin
							out_item.y_value <= 32'sh7FFF_FFFF;
							out_item.saturated <= 1'b1;
						end else if (acc_q < -48'sh8000_0000) begin
							out_item.y_value <= -32'sh8000_0000;
							out_item.saturated <= 1'b1;
						end else begin
							out_item.y_value <= acc_hi;
							out_item.saturated <= 1'b0;
						end
						acc_q <= '0;
					end
					st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
			wait_q <= m_start;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("result changed while stalled");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		st_q != S_IDLE |-> !in_ready)
		else $error("item taken while busy");
	a_mul_one: assert property (@(posedge clk) disable iff (!arst_n)
		m_start |=> !m_start)
		else $error("multiplier issued twice in a row");
	a_wait: assert property (@(posedge clk) disable iff (!arst_n)
		wait_q |-> !m_done)
		else $error("multiplier returned too early");
endmodule
